[rtl/core/cma_pkg.sv]
`timescale 1ns / 1ps
// cma_pkg: shared types, constants and helper functions for the calendar minute adder
// no dependencies

package cma_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 16;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int STAT_W  = 2;
    localparam int SDAY_W  = 6;
    localparam int SMON_W  = 4;
    localparam int SYEAR_W = 17;
    localparam int SHOUR_W = 5;
    localparam int SMIN_W  = 6;
    localparam int AMT_W   = 32;
    localparam int QUO_W   = 27;
    localparam int REM_W   = 10;
    localparam int TDAY_W  = 9;
    localparam int DCON_W  = 9;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_ADD = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NEG  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_WRAP = 2'd2;

    localparam logic [YEAR_W-1:0]  DEFAULT_YEAR = 16'd2000;
    localparam logic [MON_W-1:0]   MONTHS       = 4'd12;
    localparam logic [SHOUR_W-1:0] MAX_HOUR     = 5'd23;
    localparam logic [SMIN_W-1:0]  MAX_MINUTE   = 6'd59;

    typedef enum logic [1:0] {
        DIV_MIN  = 2'd0,
        DIV_HOUR = 2'd1,
        DIV_YEAR = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     init;
        logic     mul;
        logic     rem;
        logic     fix;
        logic     next;
        logic     walk;
        logic     commit;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic skip_div;
        logic walk_done;
    } dp_stat_t;

    typedef struct packed {
        logic [AMT_W-1:0]   add_amount;
        logic [SMIN_W-1:0]  set_minute;
        logic [SHOUR_W-1:0] set_hour;
        logic [SYEAR_W-1:0] set_year;
        logic [SMON_W-1:0]  set_month;
        logic [SDAY_W-1:0]  set_day;
        logic               operation;
    } req_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                    len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(2^k / divisor) for k = 37 and 32; one less than floor(2^40 / 365) for the year
    function automatic logic [31:0] div_mult(input div_sel_t sel);
        logic [31:0] mult;
        case (sel)
            DIV_MIN:  mult = 32'd2290649224;
            DIV_HOUR: mult = 32'd178956970;
            DIV_YEAR: mult = 32'd3012360623;
            default:  mult = 32'd0;
        endcase
        return mult;
    endfunction

    function automatic logic [DCON_W-1:0] div_const(input div_sel_t sel);
        logic [DCON_W-1:0] dc;
        case (sel)
            DIV_MIN:  dc = 9'd60;
            DIV_HOUR: dc = 9'd24;
            DIV_YEAR: dc = 9'd365;
            default:  dc = 9'd1;
        endcase
        return dc;
    endfunction

endpackage

[rtl/core/calendar_minute_adder_unit.sv]
`timescale 1ns / 1ps
// calendar_minute_adder_unit: top level, date and time register with set and minute add
// depends on cma_pkg, cma_ctrl, cma_dpath
//
//  channel | dir | tdata (lsb first)                             | tuser
//  s_      | in  | set_day, set_month, set_year, set_hour,       | operation
//          |     | set_minute, add_amount, zero pad to 72        |
//  m_      | out | day_now, month_now, year_now, hour_now,       | status
//          |     | minute_now, zero pad to 40                    |
//
// a set or a rejected add passes through capture, decode and commit from request to result
// an add runs the three divisions, then one walk step per month crossed (0 to 11), then commit
// the three divisions share one 32x32 reciprocal multiplier, each stepping through mul, rem, fix and next
// aresetn loads 1 jan 2000 00:00; a result waits in place while m_tready is low
// the next request is taken while a result waits, and commits once it is taken

module calendar_minute_adder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // set_day, set_month, set_year, set_hour, set_minute, add_amount
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // day_now, month_now, year_now, hour_now, minute_now
    output logic [1:0]  m_tuser    // status
);
    import cma_pkg::*;

    req_t              req;
    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [DAY_W-1:0]  day_now;
    logic [MON_W-1:0]  month_now;
    logic [YEAR_W-1:0] year_now;
    logic [HOUR_W-1:0] hour_now;
    logic [MIN_W-1:0]  minute_now;
    logic [STAT_W-1:0] status;

    assign req.operation  = s_tuser;
    assign req.set_day    = s_tdata[5:0];
    assign req.set_month  = s_tdata[9:6];
    assign req.set_year   = s_tdata[26:10];
    assign req.set_hour   = s_tdata[31:27];
    assign req.set_minute = s_tdata[37:32];
    assign req.add_amount = s_tdata[69:38];

    cma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cma_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .cmd        (cmd),
        .stat       (stat),
        .day_now    (day_now),
        .month_now  (month_now),
        .year_now   (year_now),
        .hour_now   (hour_now),
        .minute_now (minute_now),
        .status     (status)
    );

    assign m_tdata = {4'd0, minute_now, hour_now, year_now, month_now, day_now};
    assign m_tuser = status;

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (month_now >= 4'd1 && month_now <= MONTHS))
        else $error("month out of range");

    a_day_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (day_now >= 5'd1 && day_now <= month_len(month_now)))
        else $error("day does not fit month");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hour_now <= MAX_HOUR && minute_now <= MAX_MINUTE
                      && status != 2'd3))
        else $error("time or status out of range");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

endmodule

[rtl/core/cma_dpath.sv]
`timescale 1ns / 1ps
// cma_dpath: calendar state, request capture, reciprocal divider and month walk
// depends on cma_pkg

module cma_dpath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cma_pkg::req_t            req,
    input  cma_pkg::dp_cmd_t         cmd,
    output cma_pkg::dp_stat_t        stat,
    output logic [cma_pkg::DAY_W-1:0]  day_now,
    output logic [cma_pkg::MON_W-1:0]  month_now,
    output logic [cma_pkg::YEAR_W-1:0] year_now,
    output logic [cma_pkg::HOUR_W-1:0] hour_now,
    output logic [cma_pkg::MIN_W-1:0]  minute_now,
    output logic [cma_pkg::STAT_W-1:0] status
);
    import cma_pkg::*;

    logic [DAY_W-1:0]  day_reg;
    logic [MON_W-1:0]  month_reg;
    logic [YEAR_W-1:0] year_reg;
    logic [HOUR_W-1:0] hour_reg;
    logic [MIN_W-1:0]  minute_reg;
    logic [STAT_W-1:0] status_reg;

    req_t              req_reg;
    logic [31:0]       x_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [REM_W-1:0]  r_reg;
    logic [MIN_W-1:0]  min_w_reg;
    logic [HOUR_W-1:0] hr_w_reg;
    logic [TDAY_W-1:0] tday_reg;
    logic [MON_W-1:0]  mon_w_reg;
    logic [YEAR_W:0]   yr_w_reg;

    logic [63:0]       prod;
    logic [QUO_W-1:0]  q_est;
    logic [31:0]       qd;
    logic [DCON_W-1:0] dconst;
    logic [DAY_W-1:0]  walk_len;

    logic [MON_W-1:0]  v_month;
    logic [DAY_W-1:0]  v_len;
    logic [DAY_W-1:0]  v_day;
    logic [YEAR_W-1:0] v_year;
    logic [HOUR_W-1:0] v_hour;
    logic [MIN_W-1:0]  v_minute;

    assign dconst = div_const(cmd.div_sel);
    assign prod   = {32'd0, x_reg} * {32'd0, div_mult(cmd.div_sel)};
    assign qd     = {5'd0, q_reg} * {23'd0, dconst};

    always_comb begin
        case (cmd.div_sel)
            DIV_MIN:  q_est = prod[63:37];
            DIV_HOUR: q_est = prod[58:32];
            DIV_YEAR: q_est = {3'd0, prod[63:40]};
            default:  q_est = '0;
        endcase
    end

    // set validation
    assign v_month  = (req_reg.set_month == 4'd0 || req_reg.set_month > MONTHS)
                      ? 4'd1 : req_reg.set_month;
    assign v_len    = month_len(v_month);
    assign v_day    = (req_reg.set_day == 6'd0 || req_reg.set_day > {1'b0, v_len})
                      ? 5'd1 : req_reg.set_day[DAY_W-1:0];
    assign v_year   = req_reg.set_year[SYEAR_W-1] ? DEFAULT_YEAR
                      : req_reg.set_year[YEAR_W-1:0];
    assign v_hour   = (req_reg.set_hour > MAX_HOUR) ? 5'd0 : req_reg.set_hour;
    assign v_minute = (req_reg.set_minute > MAX_MINUTE) ? 6'd0 : req_reg.set_minute;

    assign walk_len       = month_len(mon_w_reg);
    assign stat.walk_done = tday_reg <= {4'd0, walk_len};
    assign stat.skip_div  = (req_reg.operation == OP_SET) || req_reg.add_amount[AMT_W-1];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= req;
        end
        if (cmd.init) begin
            x_reg <= {26'd0, minute_reg} + req_reg.add_amount;
        end
        if (cmd.mul) begin
            q_reg <= q_est;
        end
        if (cmd.rem) begin
            r_reg <= x_reg[REM_W-1:0] - qd[REM_W-1:0];
        end
        if (cmd.fix && r_reg >= {1'b0, dconst}) begin
            q_reg <= q_reg + 27'd1;
            r_reg <= r_reg - {1'b0, dconst};
        end
        if (cmd.next) begin
            case (cmd.div_sel)
                DIV_MIN: begin
                    min_w_reg <= r_reg[MIN_W-1:0];
                    x_reg     <= {27'd0, hour_reg} + {5'd0, q_reg};
                end
                DIV_HOUR: begin
                    hr_w_reg <= r_reg[HOUR_W-1:0];
                    x_reg    <= {27'd0, day_reg} + {5'd0, q_reg} - 32'd1;
                end
                DIV_YEAR: begin
                    tday_reg  <= r_reg[TDAY_W-1:0] + 9'd1;
                    yr_w_reg  <= {1'b0, year_reg} + {1'b0, q_reg[YEAR_W-1:0]};
                    mon_w_reg <= month_reg;
                end
                default: begin
                    x_reg <= x_reg;
                end
            endcase
        end
        if (cmd.walk) begin
            tday_reg <= tday_reg - {4'd0, walk_len};
            if (mon_w_reg == MONTHS) begin
                mon_w_reg <= 4'd1;
                yr_w_reg  <= yr_w_reg + 17'd1;
            end else begin
                mon_w_reg <= mon_w_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg    <= 5'd1;
            month_reg  <= 4'd1;
            year_reg   <= DEFAULT_YEAR;
            hour_reg   <= '0;
            minute_reg <= '0;
            status_reg <= STAT_OK;
        end else if (cmd.commit) begin
            if (req_reg.operation == OP_SET) begin
                day_reg    <= v_day;
                month_reg  <= v_month;
                year_reg   <= v_year;
                hour_reg   <= v_hour;
                minute_reg <= v_minute;
                status_reg <= STAT_OK;
            end else if (req_reg.add_amount[AMT_W-1]) begin
                status_reg <= STAT_NEG;
            end else begin
                day_reg    <= tday_reg[DAY_W-1:0];
                month_reg  <= mon_w_reg;
                year_reg   <= yr_w_reg[YEAR_W-1:0];
                hour_reg   <= hr_w_reg;
                minute_reg <= min_w_reg;
                status_reg <= yr_w_reg[YEAR_W] ? STAT_WRAP : STAT_OK;
            end
        end
    end

    assign day_now    = day_reg;
    assign month_now  = month_reg;
    assign year_now   = year_reg;
    assign hour_now   = hour_reg;
    assign minute_now = minute_reg;
    assign status     = status_reg;

endmodule

[rtl/core/cma_ctrl.sv]
`timescale 1ns / 1ps
// cma_ctrl: sequencer for capture, three constant divisions, month walk and commit
// depends on cma_pkg

module cma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  cma_pkg::dp_stat_t stat,
    output cma_pkg::dp_cmd_t  cmd
);
    import cma_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_MUL    = 8'b0000_0100,
        S_REM    = 8'b0000_1000,
        S_FIX    = 8'b0001_0000,
        S_NEXT   = 8'b0010_0000,
        S_WALK   = 8'b0100_0000,
        S_COMMIT = 8'b1000_0000
    } state_t;

    state_t   state_reg, state_next;
    div_sel_t phase_reg, phase_next;
    logic     valid_reg, valid_next;
    logic     out_free;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        valid_next  = valid_reg && !m_tready;
        cmd         = '0;
        cmd.div_sel = phase_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.skip_div) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.init   = 1'b1;
                    phase_next = DIV_MIN;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_REM;
            end
            S_REM: begin
                cmd.rem    = 1'b1;
                state_next = S_FIX;
            end
            S_FIX: begin
                cmd.fix    = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                cmd.next = 1'b1;
                case (phase_reg)
                    DIV_MIN: begin
                        phase_next = DIV_HOUR;
                        state_next = S_MUL;
                    end
                    DIV_HOUR: begin
                        phase_next = DIV_YEAR;
                        state_next = S_MUL;
                    end
                    default: begin
                        state_next = S_WALK;
                    end
                endcase
            end
            S_WALK: begin
                if (stat.walk_done) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.walk = 1'b1;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= DIV_MIN;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

endmodule
